[rtl/b58_pkg.sv]
// shared types, constants and the alphabet lookup for the base-58 encoder
`timescale 1ns / 1ps
`default_nettype none

package b58_pkg;

    localparam int MAX_BYTES_DEF  = 32;
    localparam int MAX_DIGITS_DEF = 44;

    // one base-58 digit, the carry between cells and the folded value
    localparam int DIGIT_W = 6;
    localparam int CARRY_W = 8;
    localparam int BYTE_W  = 8;
    localparam int V_W     = DIGIT_W + BYTE_W;

    // v / 58 as (v * RECIP) >> RECIP_SH, exact for every v below 2**V_W
    localparam int RECIP    = 36158;
    localparam int RECIP_SH = 21;
    localparam int MUL_W    = V_W + 16;

    // leading zero counter saturates
    localparam int ZC_W = 6;
    localparam logic [ZC_W-1:0] ZC_MAX = '1;

    localparam logic [6:0] CHAR_ONE = 7'h31;

    // carry travelling along the row of cells
    typedef struct packed {
        logic               act;
        logic [CARRY_W-1:0] carry;
    } t_wave;

    // per-cell status seen by the controller
    typedef struct packed {
        logic grow;
        logic stop;
    } t_cell_stat;

    // digit value to ascii, alphabet without 0, O, I and l
    function automatic logic [6:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [6:0] c;
        logic [6:0] dx;
        dx = {1'b0, d};
        if (dx < 7'd9) begin
            c = 7'h31 + dx;
        end else if (dx < 7'd17) begin
            c = 7'h41 + (dx - 7'd9);
        end else if (dx < 7'd22) begin
            c = 7'h4a + (dx - 7'd17);
        end else if (dx < 7'd33) begin
            c = 7'h50 + (dx - 7'd22);
        end else if (dx < 7'd44) begin
            c = 7'h61 + (dx - 7'd33);
        end else if (dx < 7'd58) begin
            c = 7'h6d + (dx - 7'd44);
        end else begin
            c = CHAR_ONE;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/b58_cell.sv]
// one digit cell of the base-58 store: fold digit*256+carry, pass the carry on
`timescale 1ns / 1ps
`default_nettype none

module b58_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire b58_pkg::t_wave               i_wave,
    input  wire logic                         i_used,
    input  wire logic                         i_shift,
    input  wire logic [b58_pkg::DIGIT_W-1:0]  i_shift_digit,
    output b58_pkg::t_wave                    o_wave,
    output logic [b58_pkg::DIGIT_W-1:0]       o_digit,
    output b58_pkg::t_cell_stat               o_stat
);
    import b58_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic               r_act;
    logic [CARRY_W-1:0] r_carry;

    logic [DIGIT_W-1:0] w_held;
    logic [V_W-1:0]     w_v;
    logic [MUL_W-1:0]   w_prod;
    logic [CARRY_W-1:0] w_q;
    logic [V_W-1:0]     w_q58;
    logic [V_W-1:0]     w_rem;
    logic               w_carry_nz;
    logic               w_wr;

    // an unused cell folds as a zero digit
    assign w_held     = i_used ? r_digit : '0;
    assign w_v        = {w_held, {BYTE_W{1'b0}}} + V_W'(i_wave.carry);
    assign w_prod     = MUL_W'(w_v) * MUL_W'(RECIP);
    assign w_q        = w_prod[RECIP_SH +: CARRY_W];
    // q * 58 = q*64 - q*4 - q*2
    assign w_q58      = (V_W'(w_q) << 6) - (V_W'(w_q) << 2) - (V_W'(w_q) << 1);
    assign w_rem      = w_v - w_q58;
    assign w_carry_nz = (i_wave.carry != '0);

    // used cells always fold; beyond the top only while a carry remains
    assign w_wr        = i_wave.act && (i_used || w_carry_nz);
    assign o_stat.grow = i_wave.act && !i_used && w_carry_nz;
    assign o_stat.stop = i_wave.act && !i_used && !w_carry_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= w_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= w_q;
        if (w_wr) begin
            r_digit <= w_rem[DIGIT_W-1:0];
        end else if (i_shift) begin
            r_digit <= i_shift_digit;
        end
    end

    assign o_wave.act   = r_act;
    assign o_wave.carry = r_carry;
    assign o_digit      = r_digit;

endmodule

`default_nettype wire

[rtl/base58_encoder.sv]
// top level of the base-58 encoder: controller and the row of digit cells
`timescale 1ns / 1ps
`default_nettype none

// base-58 encoder, bitcoin alphabet
// input: one byte per transaction, taken at a clock edge with start high and busy low;
// i_last_byte marks the final byte of a string
// output: one character per cycle while o_strobe is high; the receiver cannot stall,
// so every character is taken in the cycle it is shown
// o_last_char marks the final character; o_overflow flags a single result with char 0
// leading zero bytes only raise the zero count; any other byte, while no overflow
// is flagged, starts a carry wave that moves one cell per cycle along the row of
// MAX_DIGITS digit cells (44 by default), and busy stays high until the wave ends
// after the last byte: a check state, then ALIGN shifts the top digit to the end of
// the row and settles, then one '1' per leading zero byte, then a state that passes
// on to the digits, then one character per digit; each character is registered and
// shows in the cycle after its state, and the strobe runs unbroken within each group
// a synchronous reset clears the controller; the digit cells need no clearing
// since only digits below the in-use count are ever read
module base58_encoder #(
    parameter int MAX_BYTES  = b58_pkg::MAX_BYTES_DEF,
    parameter int MAX_DIGITS = b58_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [b58_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic                        i_last_byte,
    output logic                             o_strobe,
    output logic [6:0]                       o_out_char,
    output logic                             o_last_char,
    output logic                             o_overflow
);
    import b58_pkg::*;

    localparam int UW = $clog2(MAX_DIGITS + 1);
    localparam int BW = $clog2(MAX_BYTES + 1);
    localparam int TW = ((ZC_W > UW) ? ZC_W : UW) + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FOLD   = 3'd1;
    localparam logic [2:0] ST_FINISH = 3'd2;
    localparam logic [2:0] ST_ALIGN  = 3'd3;
    localparam logic [2:0] ST_ZEROS  = 3'd4;
    localparam logic [2:0] ST_DIGITS = 3'd5;

    logic [2:0]      r_state,  n_state;
    logic [ZC_W-1:0] r_zc,     n_zc;
    logic            r_prefix, n_prefix;
    logic [UW-1:0]   r_used,   n_used;
    logic [UW-1:0]   r_cnt,    n_cnt;
    logic [BW-1:0]   r_bytes,  n_bytes;
    logic            r_ovf,    n_ovf;
    logic            r_last,   n_last;
    t_wave           r_wave0,  n_wave0;
    logic            r_strobe, n_strobe;
    logic [6:0]      r_char,   n_char;
    logic            r_lchar,  n_lchar;
    logic            r_oflag,  n_oflag;

    // carry chain: entry k feeds cell k, entry MAX_DIGITS leaves the top cell
    t_wave                w_wave   [0:MAX_DIGITS];
    logic [DIGIT_W-1:0]   w_digit  [0:MAX_DIGITS-1];
    logic [DIGIT_W-1:0]   w_din    [0:MAX_DIGITS-1];
    t_cell_stat           w_stat   [0:MAX_DIGITS-1];
    logic [MAX_DIGITS-1:0] w_used_vec;
    logic [MAX_DIGITS-1:0] w_grow_vec;
    logic [MAX_DIGITS-1:0] w_stop_vec;
    logic [MAX_DIGITS:0]   w_act_vec;
    logic                  w_shift;
    logic                  w_tail_act;
    logic                  w_tail_ovf;
    logic [TW-1:0]         w_total;

    assign w_wave[0]    = r_wave0;
    assign w_act_vec[0] = r_wave0.act;

    genvar k;
    generate
        for (k = 0; k < MAX_DIGITS; k++) begin : g_cell
            assign w_used_vec[k] = (r_used > UW'(k));
            if (k == 0) begin : g_bottom
                assign w_din[k] = '0;
            end else begin : g_inner
                assign w_din[k] = w_digit[k-1];
            end

            b58_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_wave        (w_wave[k]),
                .i_used        (w_used_vec[k]),
                .i_shift       (w_shift),
                .i_shift_digit (w_din[k]),
                .o_wave        (w_wave[k+1]),
                .o_digit       (w_digit[k]),
                .o_stat        (w_stat[k])
            );

            assign w_grow_vec[k]  = w_stat[k].grow;
            assign w_stop_vec[k]  = w_stat[k].stop;
            assign w_act_vec[k+1] = w_wave[k+1].act;
        end
    endgenerate

    // a carry still alive past the top cell means the store is too small
    assign w_tail_act = w_wave[MAX_DIGITS].act;
    assign w_tail_ovf = w_tail_act && (w_wave[MAX_DIGITS].carry != '0);
    assign w_total    = TW'(r_zc) + TW'(r_used);
    assign w_shift    = (r_state == ST_ALIGN && r_cnt != UW'(MAX_DIGITS))
                        || (r_state == ST_DIGITS);

    always_comb begin
        n_state     = r_state;
        n_zc        = r_zc;
        n_prefix    = r_prefix;
        n_used      = r_used;
        n_cnt       = r_cnt;
        n_bytes     = r_bytes;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_wave0     = '0;
        n_strobe    = 1'b0;
        n_char      = r_char;
        n_lchar     = r_lchar;
        n_oflag     = r_oflag;

        // new digits at the top of the store
        if (|w_grow_vec) begin
            n_used = r_used + UW'(1);
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_last = i_last_byte;
                    n_state = i_last_byte ? ST_FINISH : ST_IDLE;
                    if (r_bytes >= BW'(MAX_BYTES)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_bytes = r_bytes + BW'(1);
                    end
                    if (!r_ovf && r_bytes < BW'(MAX_BYTES)) begin
                        if (r_prefix && i_data_byte == '0) begin
                            if (r_zc != ZC_MAX) begin
                                n_zc = r_zc + ZC_W'(1);
                            end
                        end else begin
                            // launch the carry wave into the bottom cell
                            n_prefix      = 1'b0;
                            n_wave0.act   = 1'b1;
                            n_wave0.carry = i_data_byte;
                            n_state       = ST_FOLD;
                        end
                    end
                end
            end
            ST_FOLD: begin
                if ((|w_stop_vec) || w_tail_act) begin
                    if (w_tail_ovf) begin
                        n_ovf = 1'b1;
                    end
                    n_state = r_last ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (r_ovf || w_total > TW'(MAX_DIGITS)) begin
                    n_strobe = 1'b1;
                    n_char   = '0;
                    n_lchar  = 1'b1;
                    n_oflag  = 1'b1;
                    n_state  = ST_IDLE;
                    n_zc     = '0;
                    n_prefix = 1'b1;
                    n_used   = '0;
                    n_bytes  = '0;
                    n_ovf    = 1'b0;
                end else begin
                    n_cnt   = r_used;
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                // move the most significant digit to the top cell
                if (r_cnt == UW'(MAX_DIGITS)) begin
                    n_state = ST_ZEROS;
                end else begin
                    n_cnt = r_cnt + UW'(1);
                end
            end
            ST_ZEROS: begin
                if (r_zc == '0) begin
                    n_state = ST_DIGITS;
                end else begin
                    n_strobe = 1'b1;
                    n_char   = CHAR_ONE;
                    n_oflag  = 1'b0;
                    n_zc     = r_zc - ZC_W'(1);
                    n_lchar  = (r_zc == ZC_W'(1)) && (r_used == '0);
                    if (r_zc == ZC_W'(1) && r_used == '0) begin
                        n_state  = ST_IDLE;
                        n_prefix = 1'b1;
                        n_bytes  = '0;
                        n_ovf    = 1'b0;
                    end
                end
            end
            ST_DIGITS: begin
                if (r_used == '0) begin
                    n_state  = ST_IDLE;
                    n_zc     = '0;
                    n_prefix = 1'b1;
                    n_bytes  = '0;
                    n_ovf    = 1'b0;
                end else begin
                    n_strobe = 1'b1;
                    n_char   = b58_char(w_digit[MAX_DIGITS-1]);
                    n_oflag  = 1'b0;
                    n_lchar  = (r_used == UW'(1));
                    n_used   = r_used - UW'(1);
                    if (r_used == UW'(1)) begin
                        n_state  = ST_IDLE;
                        n_zc     = '0;
                        n_prefix = 1'b1;
                        n_bytes  = '0;
                        n_ovf    = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_zc     <= '0;
            r_prefix <= 1'b1;
            r_used   <= '0;
            r_bytes  <= '0;
            r_ovf    <= 1'b0;
            r_wave0  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_zc     <= n_zc;
            r_prefix <= n_prefix;
            r_used   <= n_used;
            r_bytes  <= n_bytes;
            r_ovf    <= n_ovf;
            r_wave0  <= n_wave0;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_char  <= n_char;
        r_lchar <= n_lchar;
        r_oflag <= n_oflag;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_out_char  = r_char;
    assign o_last_char = r_lchar;
    assign o_overflow  = r_oflag;

    // only one cell carries the wave at a time
    a_single_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_act_vec))
        else $error("more than one cell active in the carry wave");

    // the wave lives only while the controller waits for it
    a_wave_in_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_act_vec) |-> (r_state == ST_FOLD))
        else $error("carry wave active outside fold");

    // an overflow report is a lone final character of code zero
    a_ovf_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_overflow) |-> (o_last_char && o_out_char == '0))
        else $error("malformed overflow result");

    // the final character leaves the block idle and cleared
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_char) |-> (!busy && r_used == '0 && r_zc == '0 && r_prefix))
        else $error("state not cleared after final character");

endmodule

`default_nettype wire
